>>> rtl/core/stereo_biquad_eq_cascade_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo biquad equalizer cascade
// Shared helpers that clock every check on clk_i and mute it during reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_BIQUAD_EQ_CASCADE_TOP_MACROS_SVH
`define STEREO_BIQUAD_EQ_CASCADE_TOP_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define SBQ_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// When the trigger holds, the expectation holds in the next cycle.
`define SBQ_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (expr)) \
    else $error(msg);

`endif

>>> rtl/core/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// Sizes, codes and shared types of the stereo biquad equalizer cascade.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbq_pkg;

  // Configuration of the filter cascade.
  localparam int BAND_COUNT   = 4;
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 32;
  localparam int HIST_WIDTH   = SAMPLE_WIDTH + 8;
  localparam int COEF_FRAC    = COEF_WIDTH - 4;
  localparam int GAIN_WIDTH   = 16;
  localparam int GAIN_FRAC    = 14;
  localparam int SLOT_COUNT   = 5;
  localparam int TABLE_SIZE   = BAND_COUNT * SLOT_COUNT;
  localparam int CH_COUNT     = 2;

  // Derived widths.
  localparam int COEF_IDX_W  = 5;
  localparam int COEF_ADDR_W = $clog2(TABLE_SIZE);
  localparam int BAND_W      = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int STEP_W      = 3;
  localparam int PROD_W      = COEF_WIDTH + HIST_WIDTH;
  localparam int ACC_W       = PROD_W + 3;

  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(16384);
  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC;

  // Request codes.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  // Coefficient slots of a band, plus the drain step after the last product.
  localparam logic [STEP_W-1:0] SLOT_B0    = 3'd0;
  localparam logic [STEP_W-1:0] SLOT_B1    = 3'd1;
  localparam logic [STEP_W-1:0] SLOT_B2    = 3'd2;
  localparam logic [STEP_W-1:0] SLOT_A1    = 3'd3;
  localparam logic [STEP_W-1:0] SLOT_A2    = 3'd4;
  localparam logic [STEP_W-1:0] SLOT_DRAIN = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_BAND_WB,
    ST_GAIN_MUL,
    ST_GAIN_RND
  } sbq_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              sample_load;
    logic              coef_wr;
    logic              mul_coef;
    logic              mul_gain;
    logic [STEP_W-1:0] slot;
    logic [BAND_W-1:0] band;
    logic              acc_load;
    logic              acc_add;
    logic              acc_neg;
    logic              band_wb;
    logic              out_load;
  } sbq_cmd_t;

  // Direct Form I history of one band and channel.
  typedef struct packed {
    logic signed [HIST_WIDTH-1:0] x1;
    logic signed [HIST_WIDTH-1:0] x2;
    logic signed [HIST_WIDTH-1:0] y1;
    logic signed [HIST_WIDTH-1:0] y2;
  } sbq_hist_row_t;

endpackage

>>> rtl/core/sbq_if.sv
// ----------------------------------------------------------------------------
// sbq_if
// Valid/ready channels of the equalizer: input items, results, gain writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbq_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     req_type;
  logic signed [sbq_pkg::SAMPLE_WIDTH-1:0]  sample_left;
  logic signed [sbq_pkg::SAMPLE_WIDTH-1:0]  sample_right;
  logic                                     block_end;
  logic        [sbq_pkg::COEF_IDX_W-1:0]    coef_index;
  logic signed [sbq_pkg::COEF_WIDTH-1:0]    coef_value;

  modport source (output valid, req_type, sample_left, sample_right, block_end,
                  coef_index, coef_value, input ready);
  modport sink   (input valid, req_type, sample_left, sample_right, block_end,
                  coef_index, coef_value, output ready);
endinterface

interface sbq_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [sbq_pkg::SAMPLE_WIDTH-1:0]  out_left;
  logic signed [sbq_pkg::SAMPLE_WIDTH-1:0]  out_right;
  logic                                     end_of_block;

  modport source (output valid, out_left, out_right, end_of_block, input ready);
  modport sink   (input valid, out_left, out_right, end_of_block, output ready);
endinterface

interface sbq_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sbq_pkg::GAIN_WIDTH-1:0]    master_gain;

  modport source (output valid, master_gain, input ready);
  modport sink   (input valid, master_gain, output ready);
endinterface

>>> rtl/core/sbq_ctrl.sv
// ----------------------------------------------------------------------------
// sbq_ctrl
// Sequencer that walks the multiply-accumulate steps of every band, the gain
// stage and the result handoff, and owns the item handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stereo_biquad_eq_cascade_top_macros.svh"

module sbq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              req_type_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output sbq_pkg::sbq_cmd_t cmd_o
);

  sbq_pkg::sbq_state_e                 state_q, state_d;
  logic [sbq_pkg::STEP_W-1:0]          step_q, step_d;
  logic [sbq_pkg::BAND_W-1:0]          band_q, band_d;
  logic                                out_valid_q, out_valid_d;
  sbq_pkg::sbq_cmd_t                   cmd;
  logic                                in_ready;

  // State, step and band registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbq_pkg::ST_IDLE;
      step_q      <= sbq_pkg::SLOT_B0;
      band_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      band_q      <= band_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    band_d      = band_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.slot    = step_q;
    cmd.band    = band_q;
    case (state_q)
      sbq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == sbq_pkg::REQ_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.sample_load = 1'b1;
            state_d         = sbq_pkg::ST_MAC;
            step_d          = sbq_pkg::SLOT_B0;
            band_d          = '0;
          end
        end
      end
      sbq_pkg::ST_MAC: begin
        // Products are registered after issue, so the accumulator works on step - 1.
        cmd.mul_coef = (step_q != sbq_pkg::SLOT_DRAIN);
        cmd.acc_load = (step_q == sbq_pkg::SLOT_B1);
        cmd.acc_add  = (step_q != sbq_pkg::SLOT_B0) && (step_q != sbq_pkg::SLOT_B1);
        cmd.acc_neg  = (step_q == sbq_pkg::SLOT_A2) || (step_q == sbq_pkg::SLOT_DRAIN);
        if (step_q == sbq_pkg::SLOT_DRAIN) begin
          state_d = sbq_pkg::ST_BAND_WB;
          step_d  = sbq_pkg::SLOT_B0;
        end else begin
          step_d = step_q + sbq_pkg::STEP_W'(1);
        end
      end
      sbq_pkg::ST_BAND_WB: begin
        cmd.band_wb = 1'b1;
        if (band_q == sbq_pkg::BAND_W'(sbq_pkg::BAND_COUNT - 1)) begin
          band_d  = '0;
          state_d = sbq_pkg::ST_GAIN_MUL;
        end else begin
          band_d  = band_q + sbq_pkg::BAND_W'(1);
          state_d = sbq_pkg::ST_MAC;
        end
      end
      sbq_pkg::ST_GAIN_MUL: begin
        cmd.mul_gain = 1'b1;
        state_d      = sbq_pkg::ST_GAIN_RND;
      end
      sbq_pkg::ST_GAIN_RND: begin
        // Wait here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = sbq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sbq_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `SBQ_ASSERT_HOLDS(a_no_overwrite, !cmd.out_load || !out_valid_q || out_ready_i, "pending result overwritten")
  `SBQ_ASSERT_NEXT(a_sample_start, cmd.sample_load, state_q == sbq_pkg::ST_MAC && step_q == sbq_pkg::SLOT_B0 && band_q == '0, "sample item did not start at band zero")
  `SBQ_ASSERT_NEXT(a_band_drain, state_q == sbq_pkg::ST_MAC && step_q == sbq_pkg::SLOT_DRAIN, state_q == sbq_pkg::ST_BAND_WB, "band did not write back after drain")
  `SBQ_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid_o && state_q == sbq_pkg::ST_IDLE, "result not presented after load")

endmodule

>>> rtl/core/sbq_dp.sv
// ----------------------------------------------------------------------------
// sbq_dp
// Datapath: coefficient table, one shared multiplier and accumulator per
// channel, rotating band history, rounding, saturation and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbq_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  sbq_pkg::sbq_cmd_t                       cmd_i,
  input  logic [sbq_pkg::GAIN_WIDTH-1:0]          master_gain_i,
  input  logic signed [sbq_pkg::SAMPLE_WIDTH-1:0] sample_left_i,
  input  logic signed [sbq_pkg::SAMPLE_WIDTH-1:0] sample_right_i,
  input  logic                                    block_end_i,
  input  logic [sbq_pkg::COEF_IDX_W-1:0]          coef_index_i,
  input  logic signed [sbq_pkg::COEF_WIDTH-1:0]   coef_value_i,
  output logic signed [sbq_pkg::SAMPLE_WIDTH-1:0] out_left_o,
  output logic signed [sbq_pkg::SAMPLE_WIDTH-1:0] out_right_o,
  output logic                                    end_of_block_o
);

  localparam int HW    = sbq_pkg::HIST_WIDTH;
  localparam int SW    = sbq_pkg::SAMPLE_WIDTH;
  localparam int CW    = sbq_pkg::COEF_WIDTH;
  localparam int PW    = sbq_pkg::PROD_W;
  localparam int AW    = sbq_pkg::ACC_W;
  localparam int BSH_W = AW - sbq_pkg::COEF_FRAC;
  localparam int GSH_W = PW - sbq_pkg::GAIN_FRAC;
  localparam logic signed [AW-1:0] BAND_HALF = AW'(1) << (sbq_pkg::COEF_FRAC - 1);
  localparam logic signed [PW-1:0] GAIN_HALF = PW'(1) << (sbq_pkg::GAIN_FRAC - 1);

  logic signed [CW-1:0]               coef_q [sbq_pkg::TABLE_SIZE];
  logic [sbq_pkg::COEF_ADDR_W-1:0]    coef_rd_addr;
  logic signed [CW-1:0]               coef_rd;
  logic                               eob_q;
  logic signed [SW-1:0]               sample_in [sbq_pkg::CH_COUNT];
  logic signed [SW-1:0]               result    [sbq_pkg::CH_COUNT];

  assign sample_in[0] = sample_left_i;
  assign sample_in[1] = sample_right_i;

  // Coefficient table, reset to passthrough and written by coefficient items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sbq_pkg::TABLE_SIZE; i++) begin
        coef_q[i] <= ((i % sbq_pkg::SLOT_COUNT) == 0) ? sbq_pkg::COEF_ONE : '0;
      end
    end else if (cmd_i.coef_wr && (int'(coef_index_i) < sbq_pkg::TABLE_SIZE)) begin
      coef_q[sbq_pkg::COEF_ADDR_W'(coef_index_i)] <= coef_value_i;
    end
  end

  // Coefficient read for the current band and slot; addresses past the table read zero.
  assign coef_rd_addr = sbq_pkg::COEF_ADDR_W'(cmd_i.band) *
                        sbq_pkg::COEF_ADDR_W'(sbq_pkg::SLOT_COUNT) +
                        sbq_pkg::COEF_ADDR_W'(cmd_i.slot);
  assign coef_rd = (int'(coef_rd_addr) < sbq_pkg::TABLE_SIZE) ? coef_q[coef_rd_addr] : '0;

  // Block end flag travels with the item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_load) begin
      eob_q <= block_end_i;
    end else if (cmd_i.out_load) begin
      end_of_block_o <= eob_q;
    end
  end

  for (genvar ch = 0; ch < sbq_pkg::CH_COUNT; ch++) begin : gen_lane
    sbq_pkg::sbq_hist_row_t        hist_q [sbq_pkg::BAND_COUNT];
    sbq_pkg::sbq_hist_row_t        row_new;
    logic signed [HW-1:0]          x_q;
    logic signed [HW-1:0]          operand;
    logic signed [CW-1:0]          mul_a;
    logic signed [HW-1:0]          mul_b;
    logic signed [PW-1:0]          prod_d;
    logic signed [PW-1:0]          prod_q;
    logic signed [AW-1:0]          prod_ext;
    logic signed [AW-1:0]          acc_q;
    logic signed [AW-1:0]          band_sum;
    logic [BSH_W-1:0]              band_sh;
    logic [BSH_W-HW:0]             band_top;
    logic signed [HW-1:0]          band_y;
    logic signed [PW-1:0]          gain_sum;
    logic [GSH_W-1:0]              gain_sh;
    logic [GSH_W-SW:0]             gain_top;
    logic signed [SW-1:0]          gain_y;
    logic signed [SW-1:0]          res_q;

    // History operand of the current slot; the current band's row always sits
    // at index zero.
    always_comb begin
      case (cmd_i.slot)
        sbq_pkg::SLOT_B0: operand = x_q;
        sbq_pkg::SLOT_B1: operand = hist_q[0].x1;
        sbq_pkg::SLOT_B2: operand = hist_q[0].x2;
        sbq_pkg::SLOT_A1: operand = hist_q[0].y1;
        sbq_pkg::SLOT_A2: operand = hist_q[0].y2;
        default:          operand = x_q;
      endcase
    end

    // Shared multiplier: coefficient times history, or gain times cascade out.
    assign mul_a  = cmd_i.mul_gain ? CW'(master_gain_i) : coef_rd;
    assign mul_b  = cmd_i.mul_gain ? x_q : operand;
    assign prod_d = mul_a * mul_b;

    always_ff @(posedge clk_i) begin
      if (cmd_i.mul_coef || cmd_i.mul_gain) begin
        prod_q <= prod_d;
      end
    end

    // Accumulator; feedback terms are subtracted.
    assign prod_ext = AW'(prod_q);

    always_ff @(posedge clk_i) begin
      if (cmd_i.acc_load) begin
        acc_q <= prod_ext;
      end else if (cmd_i.acc_add) begin
        acc_q <= cmd_i.acc_neg ? acc_q - prod_ext : acc_q + prod_ext;
      end
    end

    // Band output: round half up, drop the coefficient fraction, saturate.
    assign band_sum = acc_q + BAND_HALF;
    assign band_sh  = band_sum[AW-1:sbq_pkg::COEF_FRAC];
    assign band_top = band_sh[BSH_W-1:HW-1];

    always_comb begin
      if ((&band_top) || !(|band_top)) begin
        band_y = band_sh[HW-1:0];
      end else if (band_sh[BSH_W-1]) begin
        band_y = {1'b1, {(HW-1){1'b0}}};
      end else begin
        band_y = {1'b0, {(HW-1){1'b1}}};
      end
    end

    assign row_new = '{x1: x_q, x2: hist_q[0].x1, y1: band_y, y2: hist_q[0].y1};

    // Band input register: the sample, then each band's output.
    always_ff @(posedge clk_i) begin
      if (cmd_i.sample_load) begin
        x_q <= HW'(sample_in[ch]);
      end else if (cmd_i.band_wb) begin
        x_q <= band_y;
      end
    end

    // History rows rotate by one band at each write-back.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int b = 0; b < sbq_pkg::BAND_COUNT; b++) begin
          hist_q[b] <= '0;
        end
      end else if (cmd_i.band_wb) begin
        for (int b = 0; b < sbq_pkg::BAND_COUNT - 1; b++) begin
          hist_q[b] <= hist_q[b + 1];
        end
        hist_q[sbq_pkg::BAND_COUNT - 1] <= row_new;
      end
    end

    // Master gain: round half up, drop the gain fraction, saturate to samples.
    assign gain_sum = prod_q + GAIN_HALF;
    assign gain_sh  = gain_sum[PW-1:sbq_pkg::GAIN_FRAC];
    assign gain_top = gain_sh[GSH_W-1:SW-1];

    always_comb begin
      if ((&gain_top) || !(|gain_top)) begin
        gain_y = gain_sh[SW-1:0];
      end else if (gain_sh[GSH_W-1]) begin
        gain_y = {1'b1, {(SW-1){1'b0}}};
      end else begin
        gain_y = {1'b0, {(SW-1){1'b1}}};
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.out_load) begin
        res_q <= gain_y;
      end
    end

    assign result[ch] = res_q;
  end

  assign out_left_o  = result[0];
  assign out_right_o = result[1];

endmodule

>>> rtl/core/stereo_biquad_eq_cascade_top.sv
// A sample item, from acceptance to the next ready, passes an accept step, then per band
// five products through the channel's shared multiplier, a drain and a write-back, then
// the master gain multiply and the rounding, which waits for a free output register.
// The result is valid once rounding loads it; a coefficient item is written on acceptance.
// Reset restores passthrough coefficients, clears the filter history and sets unity gain.
// ----------------------------------------------------------------------------
// stereo_biquad_eq_cascade_top
// Four-band Direct Form I biquad cascade per stereo channel with master gain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_biquad_eq_cascade_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbq_in_if.sink    in_i,
  sbq_out_if.source out_o,
  sbq_cfg_if.sink   cfg_i
);

  sbq_pkg::sbq_cmd_t               cmd;
  logic [sbq_pkg::GAIN_WIDTH-1:0]  master_gain_q;
  logic                            in_ready;
  logic                            out_valid;

  // Master gain register; writes are taken at any time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_gain_q <= sbq_pkg::GAIN_RESET;
    end else if (cfg_i.valid) begin
      master_gain_q <= cfg_i.master_gain;
    end
  end

  assign cfg_i.ready = 1'b1;

  sbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .req_type_i  (in_i.req_type),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  sbq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .master_gain_i  (master_gain_q),
    .sample_left_i  (in_i.sample_left),
    .sample_right_i (in_i.sample_right),
    .block_end_i    (in_i.block_end),
    .coef_index_i   (in_i.coef_index),
    .coef_value_i   (in_i.coef_value),
    .out_left_o     (out_o.out_left),
    .out_right_o    (out_o.out_right),
    .end_of_block_o (out_o.end_of_block)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule
